>>> design/huffman_encoder_bit_packer_core_macros.svh
// Assertion macros for the Huffman encoder bit packer.
`ifndef HUFFMAN_ENCODER_BIT_PACKER_CORE_MACROS_SVH
`define HUFFMAN_ENCODER_BIT_PACKER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HEBP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define HEBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define HEBP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define HEBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> design/hebp_pkg.sv
// Types and constants of the Huffman encoder bit packer.
`timescale 1ns / 1ps
package hebp_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int SYM_W        = 8;
  localparam int TABLE_DEPTH  = 256;
  localparam int BYTE_W       = 8;
  localparam int MAX_BYTES    = 4;
  localparam int WIN_W        = CODE_W + BYTE_W;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_ENC   = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  length;
  } entry_t;

endpackage

>>> design/huffman_encoder_bit_packer_core.sv
// Huffman encoder bit packer: code table RAM, byte accumulator and output byte queue.
// The item and its table read are registered in stage 1, then its bytes in the output byte queue.
// Throughput: one item per cycle while each item yields at most one byte
// and out_stall is low; an n-byte encode (n <= 4) holds the byte queue until drained.
// Reset: synchronous, active low; clears the table valid bits (all lengths read 0),
// the accumulator and the pipeline. The table RAM itself is not swept.
`timescale 1ns / 1ps
`include "huffman_encoder_bit_packer_core_macros.svh"
module huffman_encoder_bit_packer_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hebp_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hebp_pkg::out_item_t out_data
);

  localparam int CNT_W = $clog2(hebp_pkg::MAX_BYTES + 1);

  // table RAM, one write and one registered read per cycle
  hebp_pkg::entry_t mem [hebp_pkg::TABLE_DEPTH];
  hebp_pkg::entry_t rd_r;
  logic [hebp_pkg::TABLE_DEPTH-1:0] tvld_r;

  logic                        in_acc;
  logic                        wr_en;
  hebp_pkg::entry_t            wr_ent;
  logic [hebp_pkg::LEN_W-1:0]  sat_len;
  logic [hebp_pkg::CODE_W-1:0] code_mask;

  // stage 1: item waiting for the accumulator
  logic                        s1_v_r;
  logic [1:0]                  s1_mode_r;
  logic                        s1_tv_r;
  logic                        s1_adv;

  // accumulator
  logic [hebp_pkg::BYTE_W-1:0] acc_r, acc_nxt;
  logic [2:0]                  pend_r, pend_nxt;

  // stage 2: output byte queue
  logic [hebp_pkg::CODE_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        q_free;

  logic [hebp_pkg::LEN_W-1:0]  eff_len;
  logic [hebp_pkg::CODE_W-1:0] code_l;
  logic [hebp_pkg::WIN_W-1:0]  win, win_sh;
  logic [hebp_pkg::LEN_W:0]    tot;
  logic [CNT_W-1:0]            nb;

  assign q_free   = (cnt_r == '0) || (cnt_r == CNT_W'(1) && !out_stall);
  assign s1_adv   = s1_v_r && q_free;
  assign in_stall = s1_v_r && !q_free;
  assign in_acc   = in_valid && !in_stall;
  assign wr_en    = in_acc && (in_data.mode == hebp_pkg::MODE_LOAD);

  always_comb begin
    sat_len = (in_data.code_length > hebp_pkg::LEN_W'(hebp_pkg::MAX_CODE_LEN)) ?
              hebp_pkg::LEN_W'(hebp_pkg::MAX_CODE_LEN) : in_data.code_length;
    code_mask = (sat_len >= hebp_pkg::LEN_W'(hebp_pkg::CODE_W)) ? '1 :
                ~({hebp_pkg::CODE_W{1'b1}} << sat_len);
    wr_ent.code   = in_data.code_bits & code_mask;
    wr_ent.length = sat_len;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[in_data.symbol] <= wr_ent;
    end
    if (in_acc) begin
      rd_r <= mem[in_data.symbol];
    end
  end

  // window: pending bits from the top, code left-aligned right after them
  always_comb begin
    eff_len  = s1_tv_r ? rd_r.length : '0;
    code_l   = rd_r.code << (hebp_pkg::LEN_W'(hebp_pkg::CODE_W) - eff_len);
    win      = {acc_r, {hebp_pkg::CODE_W{1'b0}}} |
               ({code_l, {hebp_pkg::BYTE_W{1'b0}}} >> pend_r);
    tot      = (hebp_pkg::LEN_W + 1)'(pend_r) + (hebp_pkg::LEN_W + 1)'(eff_len);
    nb       = CNT_W'(tot >> 3);
    win_sh   = win << {nb, 3'b000};
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    if (out_valid && !out_stall) begin
      q_nxt   = q_r << hebp_pkg::BYTE_W;
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    if (s1_adv) begin
      case (s1_mode_r)
        hebp_pkg::MODE_FLUSH: begin
          q_nxt    = {acc_r, {(hebp_pkg::CODE_W - hebp_pkg::BYTE_W){1'b0}}};
          cnt_nxt  = (pend_r != '0) ? CNT_W'(1) : '0;
          acc_nxt  = '0;
          pend_nxt = '0;
        end
        default: begin
          q_nxt    = win[hebp_pkg::WIN_W-1 -: hebp_pkg::CODE_W];
          cnt_nxt  = nb;
          acc_nxt  = win_sh[hebp_pkg::WIN_W-1 -: hebp_pkg::BYTE_W];
          pend_nxt = tot[2:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvld_r    <= '0;
      s1_v_r    <= 1'b0;
      s1_mode_r <= hebp_pkg::MODE_ENC;
      s1_tv_r   <= 1'b0;
      acc_r     <= '0;
      pend_r    <= '0;
      cnt_r     <= '0;
    end else begin
      if (wr_en) begin
        tvld_r[in_data.symbol] <= 1'b1;
      end
      if (in_acc) begin
        s1_v_r    <= (in_data.mode == hebp_pkg::MODE_ENC) ||
                     (in_data.mode == hebp_pkg::MODE_FLUSH);
        s1_mode_r <= in_data.mode;
        s1_tv_r   <= tvld_r[in_data.symbol];
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // queue payload needs no reset
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_valid         = (cnt_r != '0);
  assign out_data.out_byte = q_r[hebp_pkg::CODE_W-1 -: hebp_pkg::BYTE_W];
  assign out_data.last     = (cnt_r == CNT_W'(1));

  `HEBP_ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_r <= CNT_W'(hebp_pkg::MAX_BYTES), "byte queue overfilled")
  `HEBP_ASSERT_ALWAYS(a_acc_clean, clk, rst_n, (acc_r & (8'hFF >> pend_r)) == 8'h00, "accumulator bits set below pending count")
  `HEBP_ASSERT_NEXT(a_flush_clr, clk, rst_n, s1_adv && s1_mode_r == hebp_pkg::MODE_FLUSH, pend_r == 3'd0 && acc_r == 8'h00, "flush left pending bits")

endmodule
